FILE: hdl/hbsa_pkg.sv
// Shared types, constants and the find-first-zero helper for the slot allocator.
`default_nettype none

package hbsa_pkg;

    localparam int WORD_BITS   = 32;
    localparam int MID_WORDS   = 32;
    localparam int LEAF_WORDS  = 1024;
    localparam int SLOT_W      = 15;
    localparam int ESIZE_W     = 13;
    localparam int OFFSET_W    = 27;
    localparam int COUNT_W     = 16;
    localparam int BIT_IDX_W   = 5;
    localparam int LEAF_IDX_W  = 10;
    localparam int PROD_W      = SLOT_W + ESIZE_W;

    typedef enum logic [1:0] {
        ST_GRANTED   = 2'd0,
        ST_FULL      = 2'd1,
        ST_FREED     = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } hbsa_status_t;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic mid_rd;
        logic alloc_wr;
        logic free_wr;
        logic res_full;
        logic res_grant;
    } hbsa_cmd_t;

    typedef struct packed {
        logic top_full;
        logic mid_full;
        logic leaf_full;
        logic clr_last;
    } hbsa_stat_t;

    function automatic logic [BIT_IDX_W-1:0] ffz(input logic [WORD_BITS-1:0] w);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!w[b]) begin
                idx = BIT_IDX_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hbsa_ctrl.sv
// Control state machine that sequences clearing, allocate and free requests.
`default_nettype none

module hbsa_ctrl
    import hbsa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       mode,
    input  wire hbsa_stat_t stat,
    output hbsa_cmd_t       cmd,
    output logic            busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MID,
        S_LEAF,
        S_MUL,
        S_FREE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (mode)
                    begin
                        state_next = S_FREE;
                    end
                    else if (stat.top_full)
                    begin
                        cmd.res_full = 1'b1;
                    end
                    else
                    begin
                        state_next = S_MID;
                    end
                end
            end
            S_MID:
            begin
                state_next = S_IDLE;
                if (stat.mid_full)
                begin
                    cmd.res_full = 1'b1;
                end
                else
                begin
                    cmd.mid_rd = 1'b1;
                    state_next = S_LEAF;
                end
            end
            S_LEAF:
            begin
                state_next = S_IDLE;
                if (stat.leaf_full)
                begin
                    cmd.res_full = 1'b1;
                end
                else
                begin
                    cmd.alloc_wr = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.res_grant = 1'b1;
                state_next    = S_IDLE;
            end
            S_FREE:
            begin
                cmd.free_wr = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hbsa_dp.sv
// Datapath with the three bitmap levels, leaf memory, counters and result registers.
`default_nettype none

module hbsa_dp
    import hbsa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [SLOT_W-1:0]   slot,
    input  wire logic                cfg_wr,
    input  wire logic [ESIZE_W-1:0]  cfg_data,
    input  wire hbsa_cmd_t           cmd,
    output hbsa_stat_t               stat,
    output logic                     done,
    output logic [1:0]               status,
    output logic [SLOT_W-1:0]        granted_slot,
    output logic [OFFSET_W-1:0]      byte_offset,
    output logic [COUNT_W-1:0]       used_count
);

    logic [WORD_BITS-1:0]  top_reg;
    logic [WORD_BITS-1:0]  mid_reg [MID_WORDS];
    logic [WORD_BITS-1:0]  leaf_mem [LEAF_WORDS];
    logic [WORD_BITS-1:0]  leaf_q_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic [COUNT_W-1:0]    cnt_next;
    logic [ESIZE_W-1:0]    esize_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [BIT_IDX_W-1:0]  i_reg;
    logic [LEAF_IDX_W-1:0] j_reg;
    logic [LEAF_IDX_W-1:0] clr_reg;

    logic                  done_reg;
    hbsa_status_t          status_reg;
    logic [SLOT_W-1:0]     gslot_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [COUNT_W-1:0]    count_reg;

    logic [WORD_BITS-1:0]  mid_sel;
    logic [BIT_IDX_W-1:0]  jb;
    logic [BIT_IDX_W-1:0]  kb;
    logic [WORD_BITS-1:0]  leaf_set;
    logic [WORD_BITS-1:0]  mid_set;
    logic                  bit_used;
    logic [PROD_W-1:0]     product;

    logic                  mem_we;
    logic [LEAF_IDX_W-1:0] mem_wa;
    logic [WORD_BITS-1:0]  mem_wd;
    logic                  mem_re;
    logic [LEAF_IDX_W-1:0] mem_ra;

    assign mid_sel  = mid_reg[i_reg];
    assign jb       = ffz(mid_sel);
    assign kb       = ffz(leaf_q_reg);
    assign leaf_set = leaf_q_reg | (WORD_BITS'(1) << kb);
    assign mid_set  = mid_sel | (WORD_BITS'(1) << j_reg[BIT_IDX_W-1:0]);
    assign bit_used = leaf_q_reg[slot_reg[BIT_IDX_W-1:0]];
    assign product  = PROD_W'(slot_reg) * PROD_W'(esize_reg);

    assign stat.top_full  = &top_reg;
    assign stat.mid_full  = &mid_sel;
    assign stat.leaf_full = &leaf_q_reg;
    assign stat.clr_last  = &clr_reg;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_reg;
        mem_wd = '0;
        if (cmd.clr_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.alloc_wr)
        begin
            mem_we = 1'b1;
            mem_wa = j_reg;
            mem_wd = leaf_set;
        end
        else if (cmd.free_wr && bit_used)
        begin
            mem_we = 1'b1;
            mem_wa = slot_reg[SLOT_W-1:BIT_IDX_W];
            mem_wd = leaf_q_reg & ~(WORD_BITS'(1) << slot_reg[BIT_IDX_W-1:0]);
        end
        mem_re = cmd.accept | cmd.mid_rd;
        mem_ra = cmd.mid_rd ? {i_reg, jb} : slot[SLOT_W-1:BIT_IDX_W];
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.alloc_wr)
        begin
            cnt_next = cnt_reg + COUNT_W'(1);
        end
        else if (cmd.free_wr && bit_used)
        begin
            cnt_next = cnt_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            leaf_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            leaf_q_reg <= leaf_mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= '0;
            for (int m = 0; m < MID_WORDS; m++)
            begin
                mid_reg[m] <= '0;
            end
            cnt_reg    <= '0;
            esize_reg  <= ESIZE_W'(1);
            clr_reg    <= '0;
            slot_reg   <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_GRANTED;
            gslot_reg  <= '0;
            offset_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= cmd.res_full | cmd.res_grant | cmd.free_wr;
            if (cfg_wr)
            begin
                esize_reg <= cfg_data;
            end
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + LEAF_IDX_W'(1);
            end
            if (cmd.accept)
            begin
                slot_reg <= slot;
                i_reg    <= ffz(top_reg);
            end
            if (cmd.mid_rd)
            begin
                j_reg <= {i_reg, jb};
            end
            if (cmd.alloc_wr)
            begin
                slot_reg <= {j_reg, kb};
                if (&leaf_set)
                begin
                    mid_reg[i_reg] <= mid_set;
                    if (&mid_set)
                    begin
                        top_reg[i_reg] <= 1'b1;
                    end
                end
            end
            if (cmd.free_wr)
            begin
                gslot_reg  <= slot_reg;
                offset_reg <= '0;
                count_reg  <= cnt_next;
                if (bit_used)
                begin
                    status_reg <= ST_FREED;
                    mid_reg[slot_reg[SLOT_W-1:LEAF_IDX_W]][slot_reg[LEAF_IDX_W-1:BIT_IDX_W]]
                        <= 1'b0;
                    top_reg[slot_reg[SLOT_W-1:LEAF_IDX_W]] <= 1'b0;
                end
                else
                begin
                    status_reg <= ST_NOT_ALLOC;
                end
            end
            if (cmd.res_full)
            begin
                status_reg <= ST_FULL;
                gslot_reg  <= '0;
                offset_reg <= '0;
                count_reg  <= cnt_reg;
            end
            if (cmd.res_grant)
            begin
                status_reg <= ST_GRANTED;
                gslot_reg  <= slot_reg;
                offset_reg <= product[OFFSET_W-1:0];
                count_reg  <= cnt_reg;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_slot = gslot_reg;
    assign byte_offset  = offset_reg;
    assign used_count   = count_reg;

endmodule

`default_nettype wire

FILE: hdl/hierarchical_bitmap_slot_allocator.sv
// Top level of the three-level bitmap slot allocator.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------------------
//  request   | start, busy             | mode, slot
//  result    | done (one-cycle strobe) | status, granted_slot, byte_offset, used_count
//  config    | cfg_valid, cfg_ready    | cfg_data (element size)
//
// An allocate request runs from acceptance to the result strobe through one top
// search, one middle search with the leaf memory read, one leaf update and one
// multiply for the byte offset. An allocate request that finds the pool full is
// answered with status full from the level that finds it full. A free request
// is bounded by the leaf memory read and write-back. After reset the leaf memory
// is cleared one word per cycle with busy high; configuration writes are taken
// at any time. The receiver cannot stall; a new request may be taken in the
// cycle its predecessor's result is strobed.
`default_nettype none

module hierarchical_bitmap_slot_allocator
    import hbsa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                mode,
    input  wire logic [SLOT_W-1:0]   slot,
    output logic                     done,
    output logic [1:0]               status,
    output logic [SLOT_W-1:0]        granted_slot,
    output logic [OFFSET_W-1:0]      byte_offset,
    output logic [COUNT_W-1:0]       used_count,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [ESIZE_W-1:0]  cfg_data
);

    hbsa_cmd_t  cmd;
    hbsa_stat_t stat;

    assign cfg_ready = 1'b1;

    hbsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    hbsa_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .slot         (slot),
        .cfg_wr       (cfg_valid & cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .done         (done),
        .status       (status),
        .granted_slot (granted_slot),
        .byte_offset  (byte_offset),
        .used_count   (used_count)
    );

endmodule

`default_nettype wire

FILE: hdl/hbsa_checker.sv
// Port-level assertions for the slot allocator and their binding to the top level.
`default_nettype none

module hbsa_checker
    import hbsa_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                mode,
    input wire logic                done,
    input wire logic [1:0]          status,
    input wire logic [SLOT_W-1:0]   granted_slot,
    input wire logic [OFFSET_W-1:0] byte_offset,
    input wire logic [COUNT_W-1:0]  used_count
);

    a_free_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode |=> ##1 done)
        else $error("free request did not complete in two cycles");

    a_alloc_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !mode |=> busy || done)
        else $error("allocate request neither started nor answered");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> granted_slot == '0 && byte_offset == '0)
        else $error("pool full result carries a slot or offset");

    a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_GRANTED |-> used_count != '0)
        else $error("grant reported with zero used count");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !done |=> $stable(used_count) || done)
        else $error("used count changed without a result");

endmodule

bind hierarchical_bitmap_slot_allocator hbsa_checker u_hbsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .done         (done),
    .status       (status),
    .granted_slot (granted_slot),
    .byte_offset  (byte_offset),
    .used_count   (used_count)
);

`default_nettype wire
